// ===== rtl/rotation_matrix_to_quaternion_top_assert.svh =====
// Assertion macros used by the checker file of the quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH

// Concurrent assertion that is switched off while reset is held.
`define RMQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define RMQ_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rmq_pkg.sv =====
// Package with the widths, types and constants of the quaternion pipeline.
package rmq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FW        = 18;                           // field width
    localparam int ARG_W     = 19;                           // sqrt argument, unsigned
    localparam int SQ_STEPS  = (ARG_W + FRAC_BITS + 1) / 2;  // root bits
    localparam int XW        = 2 * SQ_STEPS;                 // radicand width
    localparam int ROOT_W    = SQ_STEPS;
    localparam int SREM_W    = ROOT_W + 2;
    localparam int D_W       = ROOT_W + 1;                   // divisor 2*s
    localparam int NUM_W     = 19;                           // numerator magnitude
    localparam int QB        = FW;                           // quotient bits
    localparam int DREM_W    = D_W + QB;

    localparam int ST_PREP   = 1;
    localparam int ST_SQ0    = 2;
    localparam int ST_DSET   = ST_SQ0 + SQ_STEPS;
    localparam int ST_DV0    = ST_DSET + 1;
    localparam int ST_OUT    = ST_DV0 + QB;
    localparam int NSTG      = ST_OUT + 1;

    localparam int S_TDATA_W = ((9 * FW + 7) / 8) * 8;
    localparam int M_TDATA_W = ((4 * FW + 7) / 8) * 8;

    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2,
        COMP_W = 2'd3
    } comp_t;

    typedef struct packed {
        logic [8:0][FW-1:0]     m;
        comp_t                  lead;
        logic                   inval;
        logic [3:0]             neg;
        logic [3:0][NUM_W-1:0]  mag;
        logic [XW-1:0]          xrad;
        logic [SREM_W-1:0]      srem;
        logic [ROOT_W-1:0]      root;
        logic [D_W-1:0]         dvs;
        logic [3:0]             ovf;
        logic [3:0][DREM_W-1:0] drem;
        logic [3:0][QB-1:0]     quo;
        logic [3:0][FW-1:0]     qo;
    } pipe_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// Top level of the rotation-matrix-to-quaternion pipeline.
//
//  channel | direction | tdata                          | tuser
//  s_      | in        | r00..r22, 9 x 18 bit, 168 bits | none
//  m_      | out       | q_x q_y q_z q_w, 4 x 18 bits   | invalid
//
// One beat is accepted per clock cycle while the output side does not stall.
// The pipeline holds the 18 stages of the digit-by-digit square root and the
// 18 stages of the restoring dividers, one result bit per stage.
// Reset clears only the valid bits of the stages. A stall holds in place
// each full stage with no empty stage after it; empty stages keep filling.
module rotation_matrix_to_quaternion_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up, then zeros
    input  logic [rmq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // q_x, q_y, q_z, q_w from bit 0 up
    output logic [rmq_pkg::M_TDATA_W-1:0] m_tdata,
    // invalid
    output logic                          m_tuser
);
    import rmq_pkg::*;

    localparam logic signed [20:0] ONE_S   = 21'(2 ** FRAC_BITS);
    localparam logic signed [FW-1:0] OUT_MAX = FW'(2 ** (FW - 1) - 1);
    localparam logic signed [FW-1:0] OUT_MIN = FW'(-(2 ** (FW - 1)));
    localparam logic [QB-1:0] NEG_LIMIT = QB'(2 ** (FW - 1));

    pipe_t pipe_reg  [NSTG];
    pipe_t pipe_next [NSTG];
    logic  vld_reg   [NSTG];
    logic  en        [NSTG+1];

    // A stage may load when it is empty or when the stage ahead moves on.
    assign en[NSTG] = m_tready;
    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    // No input beat is taken while reset is held.
    assign s_tready = aresetn && en[0];
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tuser  = pipe_reg[NSTG-1].inval;
    assign m_tdata  = M_TDATA_W'({pipe_reg[NSTG-1].qo[3], pipe_reg[NSTG-1].qo[2],
                                  pipe_reg[NSTG-1].qo[1], pipe_reg[NSTG-1].qo[0]});

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        if (k == 0) begin : g_in
            always_comb begin
                pipe_next[k] = '0;
                for (int i = 0; i < 9; i++) begin
                    pipe_next[k].m[i] = s_tdata[i*FW +: FW];
                end
            end
        end else if (k == ST_PREP) begin : g_prep
            // Trace, branch choice, square-root argument and the numerators.
            always_comb begin
                logic signed [20:0] e [9];
                logic signed [20:0] nd [4];
                logic signed [20:0] tr;
                logic signed [20:0] arg;
                logic [ARG_W-1:0]   argu;
                comp_t              sel;
                pipe_next[k] = pipe_reg[k-1];
                for (int i = 0; i < 9; i++) begin
                    e[i] = 21'($signed(pipe_reg[k-1].m[i]));
                end
                tr = e[0] + e[4] + e[8];
                if (e[0] < e[4]) begin
                    sel = (e[4] < e[8]) ? COMP_Z : COMP_Y;
                end else begin
                    sel = (e[0] < e[8]) ? COMP_Z : COMP_X;
                end
                for (int c = 0; c < 4; c++) begin
                    nd[c] = '0;
                end
                if (tr > 0) begin
                    pipe_next[k].lead = COMP_W;
                    arg   = tr + ONE_S;
                    nd[0] = e[7] - e[5];
                    nd[1] = e[2] - e[6];
                    nd[2] = e[3] - e[1];
                end else begin
                    pipe_next[k].lead = sel;
                    unique case (sel)
                        COMP_Y: begin
                            arg   = e[4] - e[8] - e[0] + ONE_S;
                            nd[3] = e[2] - e[6];
                            nd[2] = e[7] + e[5];
                            nd[0] = e[1] + e[3];
                        end
                        COMP_Z: begin
                            arg   = e[8] - e[0] - e[4] + ONE_S;
                            nd[3] = e[3] - e[1];
                            nd[0] = e[2] + e[6];
                            nd[1] = e[5] + e[7];
                        end
                        default: begin
                            arg   = e[0] - e[4] - e[8] + ONE_S;
                            nd[3] = e[7] - e[5];
                            nd[1] = e[3] + e[1];
                            nd[2] = e[6] + e[2];
                        end
                    endcase
                end
                pipe_next[k].inval = (tr <= 0) && (arg <= 0);
                // An invalid item still runs through with a harmless argument.
                argu = pipe_next[k].inval ? ARG_W'(1) : arg[ARG_W-1:0];
                pipe_next[k].xrad = XW'(argu) << FRAC_BITS;
                pipe_next[k].srem = '0;
                pipe_next[k].root = '0;
                for (int c = 0; c < 4; c++) begin
                    pipe_next[k].neg[c] = nd[c] < 0;
                    pipe_next[k].mag[c] = nd[c] < 0 ? NUM_W'(-nd[c]) : NUM_W'(nd[c]);
                end
            end
        end else if (k < ST_DSET) begin : g_sqrt
            // One root bit per stage, two radicand bits brought down.
            always_comb begin
                logic [SREM_W-1:0] rem2;
                logic [SREM_W-1:0] trial;
                pipe_next[k] = pipe_reg[k-1];
                rem2  = {pipe_reg[k-1].srem[SREM_W-3:0],
                         pipe_reg[k-1].xrad[XW-1-2*(k-ST_SQ0) -: 2]};
                trial = {pipe_reg[k-1].root, 2'b01};
                if (rem2 >= trial) begin
                    pipe_next[k].srem = rem2 - trial;
                    pipe_next[k].root = {pipe_reg[k-1].root[ROOT_W-2:0], 1'b1};
                end else begin
                    pipe_next[k].srem = rem2;
                    pipe_next[k].root = {pipe_reg[k-1].root[ROOT_W-2:0], 1'b0};
                end
            end
        end else if (k == ST_DSET) begin : g_dset
            // Divisor 2*s, dividends |d| * one, and the overflow check.
            always_comb begin
                logic [DREM_W-1:0] dsh;
                pipe_next[k] = pipe_reg[k-1];
                pipe_next[k].dvs = {pipe_reg[k-1].root, 1'b0};
                dsh = DREM_W'(pipe_next[k].dvs) << QB;
                for (int c = 0; c < 4; c++) begin
                    pipe_next[k].drem[c] = DREM_W'(pipe_reg[k-1].mag[c]) << FRAC_BITS;
                    pipe_next[k].ovf[c]  = pipe_next[k].drem[c] >= dsh;
                    pipe_next[k].quo[c]  = '0;
                end
            end
        end else if (k < ST_OUT) begin : g_div
            // One quotient bit per stage for all four dividers.
            always_comb begin
                logic [DREM_W-1:0] sh;
                pipe_next[k] = pipe_reg[k-1];
                sh = DREM_W'(pipe_reg[k-1].dvs) << (QB - 1 - (k - ST_DV0));
                for (int c = 0; c < 4; c++) begin
                    if (pipe_reg[k-1].drem[c] >= sh) begin
                        pipe_next[k].drem[c] = pipe_reg[k-1].drem[c] - sh;
                        pipe_next[k].quo[c][QB-1-(k-ST_DV0)] = 1'b1;
                    end
                end
            end
        end else begin : g_out
            // Sign, saturation, leading component and the invalid case.
            always_comb begin
                logic [QB-1:0] q;
                pipe_next[k] = pipe_reg[k-1];
                for (int c = 0; c < 4; c++) begin
                    q = pipe_reg[k-1].quo[c];
                    if (pipe_reg[k-1].inval) begin
                        pipe_next[k].qo[c] = '0;
                    end else if (comp_t'(c) == pipe_reg[k-1].lead) begin
                        pipe_next[k].qo[c] = FW'(pipe_reg[k-1].root >> 1);
                    end else if (pipe_reg[k-1].neg[c]) begin
                        if (pipe_reg[k-1].ovf[c] || q > NEG_LIMIT) begin
                            pipe_next[k].qo[c] = OUT_MIN;
                        end else begin
                            pipe_next[k].qo[c] = FW'(-$signed({1'b0, q}));
                        end
                    end else if (pipe_reg[k-1].ovf[c] || q[QB-1]) begin
                        pipe_next[k].qo[c] = OUT_MAX;
                    end else begin
                        pipe_next[k].qo[c] = FW'(q);
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en[k]) begin
                vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

endmodule

// ===== rtl/rmq_checker.sv =====
// Port-level checker for the quaternion block, bound to its top level.
`include "rotation_matrix_to_quaternion_top_assert.svh"

module rmq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rmq_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rmq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import rmq_pkg::*;

    // A result must never appear in the cycle after reset.
    `RMQ_ASSERT_NR(a_no_out_after_rst, aclk, !aresetn |=> !m_tvalid, "result after reset")
    // A held result beat stays offered.
    `RMQ_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    // A waiting input beat stays offered with the same data.
    `RMQ_ASSERT(a_in_hold, aclk, aresetn, s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata), "input beat changed")
    // Invalid beats carry an all-zero quaternion.
    `RMQ_ASSERT(a_inv_zero, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata == '0, "invalid not zero")
    // A valid rotation is never an all-zero quaternion.
    `RMQ_ASSERT(a_nonzero, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata != '0, "zero quaternion")

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);
